### rtl/cma_pkg.sv
// ----------------------------------------------------------------------------
// Centered moving average: shared package
// Common widths and defaults used by the ring, the divider and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cma_pkg;

  // Width of one Q16.16 sample and of one average.
  localparam int SampleW = 32;

  // Width of the half width register (signed, 7 bits).
  localparam int CfgW = 7;

  // Default for the largest supported half width.
  localparam int MaxHalfWidthDef = 63;

  // Quotient bits produced by the divider in each busy cycle.
  localparam int DigitsPerCycle = 8;

endpackage

### rtl/cma_ring.sv
// ----------------------------------------------------------------------------
// Centered moving average: sample ring
// Simple dual-port memory, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cma_ring
  import cma_pkg::*;
#(
  parameter int AddrW = 7
) (
  input  logic               clk_i,
  input  logic               we_i,
  input  logic [AddrW-1:0]   waddr_i,
  input  logic [SampleW-1:0] wdata_i,
  input  logic [AddrW-1:0]   raddr_i,
  output logic [SampleW-1:0] rdata_o
);

  localparam int Depth = 2 ** AddrW;

  logic [SampleW-1:0] mem_q [Depth];
  logic [SampleW-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port with registered read data.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/cma_div.sv
// ----------------------------------------------------------------------------
// Centered moving average: window sum divider
// Signed sum over unsigned count, truncated toward zero, several quotient
// bits per cycle by restoring long division on a narrow remainder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cma_div
  import cma_pkg::*;
#(
  parameter int CntW = 7
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic signed [SampleW+CntW-1:0]  sum_i,
  input  logic        [CntW-1:0]          cnt_i,
  output logic                            done_o,
  output logic        [SampleW-1:0]       average_o
);

  localparam int SumW  = SampleW + CntW;
  localparam int DivW  = ((SumW + DigitsPerCycle - 1) / DigitsPerCycle) * DigitsPerCycle;
  localparam int Steps = DivW / DigitsPerCycle;
  localparam int StepW = $clog2(Steps + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [StepW-1:0]  step_q, step_d;
  logic [DivW-1:0]   num_q, num_d;
  logic [CntW-1:0]   rem_q, rem_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              neg_q, neg_d;
  logic              zero_q, zero_d;
  logic [SumW-1:0]   mag;
  logic [SampleW-1:0] quot;

  // Magnitude of the dividend at start.
  assign mag = sum_i[SumW-1] ? SumW'(-sum_i) : SumW'(sum_i);

  // Long division: a run of compare and subtract steps in each busy cycle, and operand load on start.
  always_comb begin
    logic [CntW:0]   trial;
    logic [CntW:0]   rem_v;
    logic [DivW-1:0] num_v;
    logic            ge;
    busy_d = busy_q;
    done_d = done_q;
    step_d = step_q;
    num_d  = num_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    zero_d = zero_q;
    rem_v  = {1'b0, rem_q};
    num_v  = num_q;
    for (int i = 0; i < DigitsPerCycle; i++) begin
      trial = {rem_v[CntW-1:0], num_v[DivW-1]};
      ge    = (trial >= {1'b0, cnt_q});
      rem_v = ge ? (trial - {1'b0, cnt_q}) : trial;
      num_v = {num_v[DivW-2:0], ge};
    end
    if (start_i) begin
      busy_d = 1'b1;
      done_d = 1'b0;
      step_d = StepW'(Steps - 1);
      num_d  = DivW'(mag);
      rem_d  = '0;
      cnt_d  = cnt_i;
      neg_d  = sum_i[SumW-1];
      zero_d = (cnt_i == '0);
    end else if (busy_q) begin
      num_d = num_v;
      rem_d = rem_v[CntW-1:0];
      if (step_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        step_d = step_q - StepW'(1);
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    num_q  <= num_d;
    rem_q  <= rem_d;
    cnt_q  <= cnt_d;
    neg_q  <= neg_d;
    zero_q <= zero_d;
  end

  // Restore the sign; an empty window gives zero.
  assign quot      = num_q[SampleW-1:0];
  assign done_o    = done_q;
  assign average_o = zero_q ? '0 : (neg_q ? (~quot + SampleW'(1)) : quot);

endmodule

### rtl/centered_moving_average_core.sv
// ----------------------------------------------------------------------------
// Centered moving average core
// Mean of each sample with its neighbors within the half width, with the
// window cut short at both ends of an array.
// ----------------------------------------------------------------------------
// Samples arrive as signed Q16.16 items with tlast on the last one of an
// array. Average i is the window sum over the samples within half_width of
// sample i divided by the number of those samples, truncated toward zero; it
// leaves once sample i+half_width has been taken, and the item with tlast
// flushes all remaining averages, the last of them carrying tlast. A half
// width of 0 passes samples through; a negative one gives a zero average per
// sample. Writing half_width clears the array in progress. Samples live in a
// ring memory with registered read data; the window sum and count are updated
// by reading back the oldest sample. Each sample written to the ring passes
// the accept, drop and evaluate states and, when it yields an average, the
// divider and the output register. Each flushed average passes a check, an
// optional drop of the oldest sample by the same ring read, and the divider,
// which produces 8 quotient bits per cycle while busy. The output register
// lets the next item enter while an average waits to be taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module centered_moving_average_core
  import cma_pkg::*;
#(
  parameter int MAX_HALF_WIDTH = MaxHalfWidthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration: half_width, signed.
  input  logic               cfg_we_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  // Input items.
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [SampleW-1:0] s_axis_tdata,   // [31:0] sample
  input  logic               s_axis_tlast,   // final_sample
  // Result items.
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [SampleW-1:0] m_axis_tdata,   // [31:0] average
  output logic               m_axis_tlast    // final_average
);

  localparam int HwW  = $clog2(MAX_HALF_WIDTH + 1);
  localparam int CntW = HwW + 1;
  localparam int SumW = SampleW + CntW;
  localparam int HrW  = CfgW - 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DROP,
    ST_EVAL,
    ST_FCHK,
    ST_FDROP,
    ST_FSTART,
    ST_DIV
  } state_e;

  state_e                state_q, state_d;
  logic [CfgW-1:0]       hw_q, hw_d;
  logic signed [SumW-1:0] sum_q, sum_d;
  logic [CntW-1:0]       wc_q, wc_d;
  logic [CntW-1:0]       rc_q, rc_d;
  logic [CntW-1:0]       wp_q, wp_d;
  logic [HwW-1:0]        d_q, d_d;
  logic                  fin_q, fin_d;
  logic                  drop_q, drop_d;
  logic                  last_q, last_d;
  logic                  flush_q, flush_d;
  logic                  zero_q, zero_d;
  logic                  out_valid_q, out_valid_d;
  logic [SampleW-1:0]    avg_q, avg_d;
  logic                  olast_q, olast_d;

  logic [HrW-1:0]        h_raw;
  logic [HrW-1:0]        h_sat;
  logic [HwW-1:0]        h;
  logic                  neg;
  logic [CntW-1:0]       full;
  logic [CntW-1:0]       hp1;
  logic                  accept;
  logic                  out_free;
  logic signed [SumW-1:0] smp_ext;
  logic signed [SumW-1:0] rd_ext;

  logic                  ring_we;
  logic [CntW-1:0]       raddr;
  logic [SampleW-1:0]    rdata;

  logic                  div_start;
  logic                  div_done;
  logic [SampleW-1:0]    div_avg;

  // Effective half width, saturated to the supported maximum.
  assign neg   = hw_q[CfgW-1];
  assign h_raw = hw_q[HrW-1:0];
  assign h_sat = (h_raw > HrW'(MAX_HALF_WIDTH)) ? HrW'(MAX_HALF_WIDTH) : h_raw;
  assign h     = h_sat[HwW-1:0];
  assign full  = {h, 1'b1};
  assign hp1   = CntW'(h) + CntW'(1);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign smp_ext       = SumW'($signed(s_axis_tdata));
  assign rd_ext        = SumW'($signed(rdata));

  // The oldest sample of the window is always read from here.
  assign raddr = wp_q - wc_q;

  cma_ring #(
    .AddrW (CntW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ring_we),
    .waddr_i (wp_q),
    .wdata_i (s_axis_tdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  cma_div #(
    .CntW (CntW)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .sum_i     (sum_q),
    .cnt_i     (wc_q),
    .done_o    (div_done),
    .average_o (div_avg)
  );

  // Sequencer: push, drop the oldest sample, divide, then walk the flush.
  always_comb begin
    state_d     = state_q;
    hw_d        = hw_q;
    sum_d       = sum_q;
    wc_d        = wc_q;
    rc_d        = rc_q;
    wp_d        = wp_q;
    d_d         = d_q;
    fin_d       = fin_q;
    drop_d      = drop_q;
    last_d      = last_q;
    flush_d     = flush_q;
    zero_d      = zero_q;
    avg_d       = avg_q;
    olast_d     = olast_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    ring_we     = 1'b0;
    div_start   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          fin_d   = s_axis_tlast;
          flush_d = 1'b0;
          if (neg) begin
            zero_d  = 1'b1;
            last_d  = s_axis_tlast;
            state_d = ST_DIV;
          end else begin
            zero_d  = 1'b0;
            ring_we = 1'b1;
            wp_d    = wp_q + CntW'(1);
            sum_d   = sum_q + smp_ext;
            drop_d  = (wc_q >= full);
            wc_d    = (wc_q >= full) ? wc_q : (wc_q + CntW'(1));
            rc_d    = (rc_q < hp1) ? (rc_q + CntW'(1)) : rc_q;
            state_d = ST_DROP;
          end
        end
      end
      ST_DROP: begin
        if (drop_q) begin
          sum_d = sum_q - rd_ext;
        end
        state_d = ST_EVAL;
      end
      ST_EVAL: begin
        if (rc_q == hp1) begin
          div_start = 1'b1;
          last_d    = fin_q && (h == '0);
          state_d   = ST_DIV;
        end else if (fin_q) begin
          d_d     = h - HwW'(1);
          flush_d = 1'b1;
          state_d = ST_FCHK;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_FCHK: begin
        if ((rc_q == hp1) || (CntW'(d_q) < rc_q)) begin
          if (wc_q > (CntW'(d_q) + CntW'(h) + CntW'(1))) begin
            wc_d    = wc_q - CntW'(1);
            state_d = ST_FDROP;
          end else begin
            div_start = 1'b1;
            last_d    = (d_q == '0);
            state_d   = ST_DIV;
          end
        end else if (d_q == '0) begin
          sum_d   = '0;
          wc_d    = '0;
          rc_d    = '0;
          wp_d    = '0;
          state_d = ST_IDLE;
        end else begin
          d_d = d_q - HwW'(1);
        end
      end
      ST_FDROP: begin
        sum_d   = sum_q - rd_ext;
        state_d = ST_FSTART;
      end
      ST_FSTART: begin
        div_start = 1'b1;
        last_d    = (d_q == '0);
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if ((zero_q || div_done) && out_free) begin
          out_valid_d = 1'b1;
          avg_d       = zero_q ? '0 : div_avg;
          olast_d     = last_q;
          if (flush_q) begin
            if (d_q == '0) begin
              sum_d   = '0;
              wc_d    = '0;
              rc_d    = '0;
              wp_d    = '0;
              state_d = ST_IDLE;
            end else begin
              d_d     = d_q - HwW'(1);
              state_d = ST_FCHK;
            end
          end else if (fin_q) begin
            if (zero_q || (h == '0)) begin
              sum_d   = '0;
              wc_d    = '0;
              rc_d    = '0;
              wp_d    = '0;
              state_d = ST_IDLE;
            end else begin
              d_d     = h - HwW'(1);
              flush_d = 1'b1;
              state_d = ST_FCHK;
            end
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // A register write sets the half width and drops the array in progress.
    if (cfg_we_i) begin
      hw_d    = cfg_wdata_i;
      sum_d   = '0;
      wc_d    = '0;
      rc_d    = '0;
      wp_d    = '0;
      state_d = ST_IDLE;
    end
  end

  // State, stream state and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hw_q        <= '0;
      sum_q       <= '0;
      wc_q        <= '0;
      rc_q        <= '0;
      wp_q        <= '0;
      d_q         <= '0;
      fin_q       <= 1'b0;
      drop_q      <= 1'b0;
      last_q      <= 1'b0;
      flush_q     <= 1'b0;
      zero_q      <= 1'b0;
      out_valid_q <= 1'b0;
      olast_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      hw_q        <= hw_d;
      sum_q       <= sum_d;
      wc_q        <= wc_d;
      rc_q        <= rc_d;
      wp_q        <= wp_d;
      d_q         <= d_d;
      fin_q       <= fin_d;
      drop_q      <= drop_d;
      last_q      <= last_d;
      flush_q     <= flush_d;
      zero_q      <= zero_d;
      out_valid_q <= out_valid_d;
      olast_q     <= olast_d;
    end
  end

  // Average payload.
  always_ff @(posedge clk_i) begin
    avg_q <= avg_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = avg_q;
  assign m_axis_tlast  = olast_q;

endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// Centered moving average core: self-checking testbench
// Streams signed Q16.16 arrays through the core under several half widths and
// flow-control patterns. A cycle-free software copy of the window predicts
// every average, and the monitor checks each one in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import cma_pkg::*;

  localparam int DrainCycles = 50;
  localparam int HoldCycles  = 300;
  localparam int QuietLimit  = 4000;

  typedef struct packed {
    logic [SampleW-1:0] value;
    logic               is_last;
  } sample_item_t;

  typedef struct packed {
    logic [SampleW-1:0] average;
    logic               is_last;
  } avg_item_t;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [CfgW-1:0]    cfg_wdata_i   = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [SampleW-1:0] s_axis_tdata  = '0;  // [31:0] sample
  logic               s_axis_tlast  = 1'b0; // final_sample
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [SampleW-1:0] m_axis_tdata;         // [31:0] average
  logic               m_axis_tlast;         // final_average

  centered_moving_average_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  // 12 ns clock.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  sample_item_t pending_samples[$];
  avg_item_t    expected_averages[$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  bit          pressure_go    = 1'b0;
  logic        rx_hold        = 1'b0;
  int          error_count    = 0;
  int          samples_sent   = 0;
  int          averages_seen  = 0;
  int          cfg_writes     = 0;
  int          quiet_cycles   = 0;

  // Software copy of the window state.
  logic [SampleW-1:0] ring_q [128];
  longint             win_sum;
  int unsigned        win_count;
  int unsigned        rcv_count;
  logic [6:0]         wr_ptr;
  logic [CfgW-1:0]    half_width_q;

  function automatic void clear_window();
    win_sum   = 0;
    win_count = 0;
    rcv_count = 0;
    wr_ptr    = '0;
  endfunction

  function automatic void drop_oldest();
    logic [6:0] idx;
    idx = wr_ptr - 7'(win_count);
    win_sum -= longint'($signed(ring_q[idx]));
    win_count--;
  endfunction

  // Mean of the current window, truncated toward zero.
  function automatic void queue_average(input logic is_last);
    longint    mean;
    avg_item_t item;
    mean = (win_count != 0) ? win_sum / longint'(win_count) : 0;
    item.average = mean[SampleW-1:0];
    item.is_last = is_last;
    expected_averages.push_back(item);
  endfunction

  // Works out every average that one accepted sample releases.
  function automatic void predict_averages(input logic [SampleW-1:0] value,
                                           input logic fin);
    int unsigned h;
    int unsigned full;
    int unsigned d;
    avg_item_t   zero_item;
    if (half_width_q[CfgW-1]) begin
      // Negative half width: one zero average per sample.
      zero_item.average = '0;
      zero_item.is_last = fin;
      expected_averages.push_back(zero_item);
      if (fin) clear_window();
      return;
    end
    h    = int'(half_width_q);
    full = 2 * h + 1;
    if (win_count >= full) drop_oldest();
    ring_q[wr_ptr] = value;
    wr_ptr         = wr_ptr + 7'd1;
    win_sum       += longint'($signed(value));
    win_count++;
    if (rcv_count < h + 1) rcv_count++;
    if (rcv_count == h + 1) queue_average(fin && h == 0);
    if (fin) begin
      // Flush the averages still waiting for right-hand neighbors.
      d = h;
      while (d > 0) begin
        d--;
        if (rcv_count == h + 1 || d < rcv_count) begin
          if (win_count > d + h + 1) drop_oldest();
          queue_average(d == 0);
        end
      end
      clear_window();
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [SampleW-1:0] got,
                                 input logic [SampleW-1:0] want);
    $display("MISMATCH %s at average %0d: got %h, expected %h", what, averages_seen,
             got, want);
    error_count++;
  endtask

  // Sender: presents queued samples, idling at random.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_averages(pending_samples[0].value, pending_samples[0].is_last);
        pending_samples.delete(0);
        samples_sent++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= pending_samples[0].value;
          s_axis_tlast  <= pending_samples[0].is_last;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each average against the oldest prediction.
  always @(posedge clk_i) begin : monitor
    avg_item_t want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_averages.size() == 0) begin
          report_mismatch("unexpected item", m_axis_tdata, '0);
        end else begin
          want = expected_averages.pop_front();
          if (m_axis_tdata !== want.average) begin
            report_mismatch("average", m_axis_tdata, want.average);
          end
          if (m_axis_tlast !== want.is_last) begin
            report_mismatch("tlast", SampleW'(m_axis_tlast), SampleW'(want.is_last));
          end
        end
        averages_seen++;
      end
      m_axis_tready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off so the core fills up and stalls its input.
  initial begin
    wait (pressure_go);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (s_axis_tvalid && s_axis_tready) ||
        (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("Timeout: no transfer for %0d cycles", QuietLimit);
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic void add_sample(input logic [SampleW-1:0] value, input logic is_last);
    sample_item_t item;
    item.value   = value;
    item.is_last = is_last;
    pending_samples.push_back(item);
  endfunction

  function automatic logic [SampleW-1:0] pick_sample();
    case ($urandom_range(7))
      0:       pick_sample = 32'h7FFF_FFFF;
      1:       pick_sample = 32'h8000_0000;
      2:       pick_sample = $urandom_range(32'h3_FFFF);
      3:       pick_sample = 32'hFFFF_FFFF - $urandom_range(32'h3_FFFF);
      default: pick_sample = $urandom;
    endcase
  endfunction

  function automatic void set_idle(input idle_mode_e mode);
    send_idle_pct  = (mode == IDLE_SENDER) ? 69 : (mode == IDLE_BOTH) ? 6 : 0;
    recv_stall_pct = (mode == IDLE_RECEIVER) ? 69 : (mode == IDLE_BOTH) ? 6 : 0;
  endfunction

  // Waits until every sample is taken and every average checked.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (pending_samples.size() != 0 || s_axis_tvalid || expected_averages.size() != 0);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Writes half_width while the core is idle; returns at a falling edge.
  task automatic set_half_width(input logic [CfgW-1:0] hw);
    wait_idle();
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= hw;
    @(posedge clk_i);
    cfg_we_i     <= 1'b0;
    half_width_q  = hw;
    clear_window();
    cfg_writes++;
    @(negedge clk_i);
  endtask

  // One random phase: arrays of random length, the last one sometimes cut off.
  task automatic run_phase(input logic [CfgW-1:0] hw, input idle_mode_e mode,
                           input int budget, input bit squeeze);
    int unsigned h;
    int          queued;
    int          len;
    bit          complete;
    set_half_width(hw);
    set_idle(mode);
    h      = hw[CfgW-1] ? 3 : int'(hw);
    queued = 0;
    while (queued < budget) begin
      case ($urandom_range(9))
        0, 1:    len = $urandom_range(h + 1, 1);
        2, 3:    len = $urandom_range(3 * h + 6, 2 * h + 2);
        default: len = $urandom_range(2 * h + 4, 1);
      endcase
      // The phase never sends more samples than its budget.
      if (len > budget - queued) len = budget - queued;
      complete = !(queued + len >= budget && $urandom_range(4) == 0);
      for (int i = 0; i < len; i++) begin
        add_sample(pick_sample(), complete && i == len - 1);
      end
      queued += len;
    end
    if (squeeze) pressure_go = 1'b1;
  endtask

  initial begin
    half_width_q = '0;
    clear_window();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Pass-through with extreme samples.
    set_half_width(7'd0);
    add_sample(32'h7FFF_FFFF, 1'b0);
    add_sample(32'h8000_0000, 1'b0);
    add_sample(32'h0000_0000, 1'b0);
    add_sample(32'hFFFF_FFFF, 1'b1);

    // Negative half width forces zero averages.
    set_half_width(7'h7F);
    add_sample(32'h1234_5678, 1'b0);
    add_sample(32'h7FFF_FFFF, 1'b0);
    add_sample(32'h8000_0000, 1'b1);

    // Arrays shorter than the half width, a single-sample array, and an array
    // of four maximum samples then four minimum ones that fills the window.
    set_half_width(7'd3);
    add_sample(32'h0001_8000, 1'b0);
    add_sample(32'hFFFF_0001, 1'b1);
    add_sample(32'h8000_0000, 1'b1);
    for (int i = 0; i < 8; i++) begin
      add_sample((i < 4) ? 32'h7FFF_FFFF : 32'h8000_0000, i == 7);
    end
    // An array cut off by a register write.
    add_sample(32'h0000_0007, 1'b0);
    add_sample(32'hFFFF_FFF9, 1'b0);

    // Largest half width with an array far shorter than the window.
    set_half_width(7'd63);
    for (int i = 0; i < 5; i++) add_sample(pick_sample(), i == 4);

    // Random phases over half widths and flow-control patterns.
    run_phase(7'd2,  IDLE_NONE,     40,  1'b1);
    run_phase(7'd1,  IDLE_SENDER,   35,  1'b0);
    run_phase(7'd63, IDLE_RECEIVER, 200, 1'b0);
    run_phase(7'h7F, IDLE_BOTH,     20,  1'b0);
    run_phase(7'd0,  IDLE_SENDER,   25,  1'b0);
    run_phase(7'($urandom_range(20, 3)), IDLE_RECEIVER, 45, 1'b0);
    run_phase(7'h40, IDLE_NONE,     15,  1'b0);
    run_phase(7'd5,  IDLE_BOTH,     35,  1'b0);
    run_phase(7'($urandom_range(63)), IDLE_NONE, 40, 1'b0);
    wait_idle();

    $display("Run covered %0d samples and %0d averages over %0d half width writes,",
             samples_sent, averages_seen, cfg_writes);
    $display("including negative and maximum widths, truncated arrays and a long stall.");
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
